// ----- rtl/mssd_pkg.sv -----
// Package for the multiplexed seven-segment clock driver: types, constants and decode functions.
package mssd_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SHOW  = 2'd1,
        OP_COLON = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // One queued byte job: the segment byte and the digit lines shown after the latch.
    typedef struct packed {
        logic [7:0] seg_byte;
        logic [3:0] lines_n;
    } job_t;

    // Read side of the job queue as seen by the serializer.
    typedef struct packed {
        logic nonempty;
        job_t head;
    } q_rd_t;

    localparam logic [3:0]  COLON_POINTS     = 4'b0110;
    localparam logic [7:0]  POINT_BIT        = 8'h80;
    localparam logic [7:0]  HOUR_MAX         = 8'd23;
    localparam logic [7:0]  MINUTE_MAX       = 8'd59;
    localparam logic [7:0]  RADIX            = 8'd10;
    localparam logic [15:0] INTERVAL_RESET   = 16'd2000;
    localparam logic [3:0]  LINES_ALL_OFF    = 4'hF;

    // Tens digit of a value below 60.
    function automatic logic [3:0] tens_of(input logic [7:0] v);
        logic [3:0] t;
        t = 4'd0;
        for (int i = 1; i <= 5; i++)
        begin
            if (v >= 8'(i * 10))
                t = 4'(i);
        end
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [7:0] v, input logic [3:0] t);
        logic [7:0] r;
        r = v - ({4'd0, t} * RADIX);
        return r[3:0];
    endfunction

    // Common-cathode pattern; the turned form swaps A/D, B/E, C/F for an upside-down digit.
    function automatic logic [7:0] seg_pattern(input logic [3:0] value, input logic turned);
        logic [7:0] p;
        unique case (value)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = 8'h3F;
        endcase
        if (turned)
            p = {1'b0, p[6], p[2], p[1], p[0], p[5], p[4], p[3]};
        return p;
    endfunction

endpackage

// ----- rtl/mssd_if.sv -----
// Channel interfaces for the command words and the serial bit words.
interface mssd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic       colon_on;

    modport source (output valid, output op, output hours, output minutes, output colon_on,
                    input ready);
    modport sink   (input valid, input op, input hours, input minutes, input colon_on,
                    output ready);
endinterface

interface mssd_out_if;
    logic       valid;
    logic       ready;
    logic       serial_bit;
    logic       last_bit;
    logic [3:0] digit_lines_n;

    modport source (output valid, output serial_bit, output last_bit, output digit_lines_n,
                    input ready);
    modport sink   (input valid, input serial_bit, input last_bit, input digit_lines_n,
                    output ready);
endinterface

// ----- rtl/mssd_front.sv -----
// Command front end: holds the digit store, points, scan state and tick counter, and queues byte jobs.
module mssd_front
    import mssd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_data,
    mssd_in_if.sink      in_ch,
    input  logic         q_full,
    output logic         q_push,
    output job_t         q_job
);

    logic [15:0] interval_reg;
    logic [7:0]  digit_store_reg [4];
    logic [7:0]  digit_store_next [4];
    logic [3:0]  point_mask_reg, point_mask_next;
    logic [1:0]  scan_index_reg, scan_index_next;
    logic [15:0] tick_count_reg, tick_count_next;

    logic        accept;
    logic [15:0] count_inc;
    logic [7:0]  hours_c;
    logic [7:0]  minutes_c;
    logic [3:0]  h_tens, m_tens;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign count_inc   = tick_count_reg + 16'd1;
    assign hours_c     = (in_ch.hours > HOUR_MAX) ? 8'd0 : in_ch.hours;
    assign minutes_c   = (in_ch.minutes > MINUTE_MAX) ? 8'd0 : in_ch.minutes;
    assign h_tens      = tens_of(hours_c);
    assign m_tens      = tens_of(minutes_c);

    always_comb
    begin
        digit_store_next = digit_store_reg;
        point_mask_next  = point_mask_reg;
        scan_index_next  = scan_index_reg;
        tick_count_next  = tick_count_reg;
        q_push           = 1'b0;
        q_job            = '0;
        if (accept)
        begin
            unique case (op_t'(in_ch.op))
                OP_TICK:
                begin
                    if (count_inc >= interval_reg)
                    begin
                        tick_count_next = 16'd0;
                        scan_index_next = scan_index_reg + 2'd1;
                        q_push          = 1'b1;
                        q_job.seg_byte  = digit_store_reg[scan_index_reg]
                                        | (point_mask_reg[scan_index_reg] ? POINT_BIT : 8'h00);
                        q_job.lines_n   = ~(4'b0001 << scan_index_reg);
                    end
                    else
                    begin
                        tick_count_next = count_inc;
                    end
                end
                OP_SHOW:
                begin
                    digit_store_next[0] = seg_pattern(h_tens, 1'b0);
                    digit_store_next[1] = seg_pattern(ones_of(hours_c, h_tens), 1'b0);
                    digit_store_next[2] = seg_pattern(m_tens, 1'b1);
                    digit_store_next[3] = seg_pattern(ones_of(minutes_c, m_tens), 1'b1);
                end
                OP_COLON:
                begin
                    point_mask_next = in_ch.colon_on ? (point_mask_reg | COLON_POINTS)
                                                     : (point_mask_reg & ~COLON_POINTS);
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < 4; i++)
                        digit_store_next[i] = 8'h00;
                    point_mask_next = 4'd0;
                    q_push          = 1'b1;
                    q_job.seg_byte  = 8'h00;
                    q_job.lines_n   = LINES_ALL_OFF;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= INTERVAL_RESET;
            for (int i = 0; i < 4; i++)
                digit_store_reg[i] <= 8'h00;
            point_mask_reg <= 4'd0;
            scan_index_reg <= 2'd0;
            tick_count_reg <= 16'd0;
        end
        else
        begin
            if (cfg_we)
                interval_reg <= cfg_data;
            digit_store_reg <= digit_store_next;
            point_mask_reg  <= point_mask_next;
            scan_index_reg  <= scan_index_next;
            tick_count_reg  <= tick_count_next;
        end
    end

endmodule

// ----- rtl/mssd_fifo.sv -----
// Short job queue between the command front end and the serializer.
module mssd_fifo
    import mssd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  job_t  push_job,
    output logic  full,
    input  logic  pop,
    output q_rd_t rd
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign rd.nonempty = (count_reg != '0);
    assign rd.head     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/mssd_back.sv -----
// Serializer: shifts each queued byte out MSB first through an output register, one bit per word.
module mssd_back
    import mssd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_rd_t      rd,
    output logic       pop,
    mssd_out_if.source out_ch
);

    logic [6:0] shift_reg, shift_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic [3:0] lines_reg, lines_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_bit_reg, out_bit_next;
    logic       out_last_reg, out_last_next;
    logic [3:0] out_lines_reg, out_lines_next;
    logic       advance;

    assign advance = !out_valid_reg || out_ch.ready;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.serial_bit    = out_bit_reg;
    assign out_ch.last_bit      = out_last_reg;
    assign out_ch.digit_lines_n = out_lines_reg;

    always_comb
    begin
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        lines_next     = lines_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_last_next  = out_last_reg;
        out_lines_next = out_lines_reg;
        pop            = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b0;
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                out_bit_next   = shift_reg[6];
                out_last_next  = (cnt_reg == 3'd7);
                out_lines_next = (cnt_reg == 3'd7) ? lines_reg : LINES_ALL_OFF;
                shift_next     = {shift_reg[5:0], 1'b0};
                cnt_next       = cnt_reg + 3'd1;
                busy_next      = (cnt_reg != 3'd7);
            end
            else if (rd.nonempty)
            begin
                // The first bit leaves straight from the queue head so bytes run back to back.
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_bit_next   = rd.head.seg_byte[7];
                out_last_next  = 1'b0;
                out_lines_next = LINES_ALL_OFF;
                shift_next     = rd.head.seg_byte[6:0];
                lines_next     = rd.head.lines_n;
                cnt_next       = 3'd1;
                busy_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 3'd0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        lines_reg     <= lines_next;
        out_bit_reg   <= out_bit_next;
        out_last_reg  <= out_last_next;
        out_lines_reg <= out_lines_next;
    end

endmodule

// ----- rtl/muxed_seven_segment_clock_driver.sv -----
// Top level of the multiplexed seven-segment clock driver.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    op, hours, minutes, colon_on
//   out_ch    out  valid/ready    serial_bit, last_bit, digit_lines_n
//   cfg       in   cfg_we         cfg_data = refresh_interval
//
// A command word is taken every cycle while the job queue has room; a word that
// starts a byte takes eight output words, and bytes follow each other with no gap
// while the output is ready, so the serializer sets the sustained byte rate.
// The queue fills and stops command words only when bytes are asked for faster than
// the output takes them.
// Reset clears all control state and the display state; the refresh interval resets to 2000.
// A stalled output holds its word while the front end keeps taking commands until the job queue is full.
module muxed_seven_segment_clock_driver
    import mssd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    mssd_in_if.sink     in_ch,
    mssd_out_if.source  out_ch
);

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    job_t  q_job;
    q_rd_t q_rd;

    mssd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    mssd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .rd       (q_rd)
    );

    mssd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (q_rd),
        .pop    (q_pop),
        .out_ch (out_ch)
    );

    // Digit lines stay all high except on the last bit of a byte.
    a_lines_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.last_bit |-> out_ch.digit_lines_n == LINES_ALL_OFF)
        else $error("digit lines active before the latch");

    // After the latch at most one digit line is low.
    a_lines_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last_bit |-> $countones(~out_ch.digit_lines_n) <= 1)
        else $error("more than one digit selected");

    // A pushed job leaves the queue nonempty in the next cycle.
    a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> q_rd.nonempty)
        else $error("queue lost a pushed job");

endmodule
